// ===== src/linear_rnn_silu_cell_top_assert.svh =====
// Assertion macros for the linear recurrent cell.
`ifndef LINEAR_RNN_SILU_CELL_TOP_ASSERT_SVH
`define LINEAR_RNN_SILU_CELL_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LRS_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LRS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LRS_ASSERT_IMPLY(name, ante, cons)
`define LRS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== src/lrs_pkg.sv =====
// Shared types, constants and the sigmoid table for the linear recurrent cell.
package lrs_pkg;

  localparam int DIM_DEF   = 16;
  localparam int LANES_DEF = 4;
  localparam int LANE_W    = 2;
  localparam int IDX_W     = 4;
  localparam int VAL_W     = 16;
  localparam int CFG_W     = 5;
  localparam int ACTIVE_DIM_RESET = 16;

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_HIDDEN = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    K_WEIGHT,
    K_BIAS,
    K_HIDDEN,
    K_SAMPLE,
    K_STEP
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [LANE_W-1:0]        lane;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [VAL_W-1:0]  value;
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SUM,
    S_SUMW,
    S_MAC,
    S_WAIT,
    S_SAT,
    S_SIG,
    S_MUL,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_stat_t;

  typedef logic [15:0] sig_rom_t [256];

  function automatic int unsigned aw(int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // sigmoid(-8 + i/16) in Q0.16, built from a repeated e^(-1/16) step
  function automatic sig_rom_t build_sig_rom();
    sig_rom_t    t;
    logic [63:0] p;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] num;
    logic [63:0] rem;
    logic [16:0] diff;
    p = 64'd1 << 32;
    for (int k = 0; k <= 128; k++) begin
      d = (64'd1 << 32) + p;
      num = (64'd1 << 48) + (d >> 1);
      // rounded quotient by shift and subtract
      rem = '0;
      s = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= d) begin
          rem = rem - d;
          s[b] = 1'b1;
        end
      end
      if (k < 128) t[128 + k] = s[15:0];
      if (k >= 1) begin
        diff = 17'h10000 - s[16:0];
        t[128 - k] = diff[15:0];
      end
      p = (p * 64'd4034748382 + (64'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

// ===== src/lrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [lrs_pkg::aw(DEPTH)-1:0]          waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [lrs_pkg::aw(DEPTH)-1:0]          raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lrs_front.sv =====
// Front end: accepts items, drops out-of-range ones, classifies and queues the rest.
module lrs_front #(
  parameter int DIM   = lrs_pkg::DIM_DEF,
  parameter int LANES = lrs_pkg::LANES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         opcode,
  input  logic [lrs_pkg::LANE_W-1:0]         lane,
  input  logic [lrs_pkg::IDX_W-1:0]          row_index,
  input  logic [lrs_pkg::IDX_W-1:0]          col_index,
  input  logic signed [lrs_pkg::VAL_W-1:0]   value,
  input  logic [lrs_pkg::aw(DIM+1)-1:0]      n,
  input  logic                               hold,
  output logic                               cmd_valid,
  input  logic                               cmd_ready,
  output lrs_pkg::cmd_t                      cmd
);

  lrs_pkg::cmd_t q [2];
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;
  logic          keep;
  lrs_pkg::kind_t kind;
  logic          push;
  logic          pop;

  always_comb begin
    keep = 1'b0;
    kind = lrs_pkg::K_WEIGHT;
    if (32'(lane) < LANES) begin
      unique case (lrs_pkg::opcode_t'(opcode))
        lrs_pkg::OP_WEIGHT: begin
          keep = (32'(row_index) < DIM) && (32'(col_index) < DIM);
          kind = lrs_pkg::K_WEIGHT;
        end
        lrs_pkg::OP_BIAS: begin
          keep = 32'(row_index) < DIM;
          kind = lrs_pkg::K_BIAS;
        end
        lrs_pkg::OP_HIDDEN: begin
          keep = 32'(row_index) < DIM;
          kind = lrs_pkg::K_HIDDEN;
        end
        lrs_pkg::OP_SAMPLE: begin
          keep = 32'(col_index) < 32'(n);
          kind = (32'(col_index) == 32'(n) - 1) ? lrs_pkg::K_STEP : lrs_pkg::K_SAMPLE;
        end
        default: keep = 1'b0;
      endcase
    end
  end

  assign in_ready  = (cnt != 2'd2) && !hold;
  assign push      = in_valid && in_ready && keep;
  assign cmd_valid = cnt != 2'd0;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp].kind  <= kind;
      q[wp].lane  <= lane;
      q[wp].row   <= row_index;
      q[wp].col   <= col_index;
      q[wp].value <= value;
    end
  end

endmodule

// ===== src/lrs_back.sv =====
// Back end: executes loads and runs the recurrent step on one shared MAC.
module lrs_back #(
  parameter int DIM   = lrs_pkg::DIM_DEF,
  parameter int LANES = lrs_pkg::LANES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [lrs_pkg::aw(DIM+1)-1:0]      n,
  input  logic                               cmd_valid,
  output logic                               cmd_ready,
  input  lrs_pkg::cmd_t                      cmd,
  output lrs_pkg::back_stat_t                stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lrs_pkg::LANE_W-1:0]         out_lane,
  output logic [lrs_pkg::IDX_W-1:0]          out_row,
  output logic signed [lrs_pkg::VAL_W-1:0]   hidden_value,
  output logic signed [lrs_pkg::VAL_W-1:0]   gated_value,
  output logic                               last_row
);

  localparam int CW    = lrs_pkg::aw(DIM + 1);
  localparam int WAW   = lrs_pkg::aw(DIM * DIM);
  localparam int HAW   = lrs_pkg::aw(LANES * DIM);
  localparam int DAW   = lrs_pkg::aw(DIM);
  localparam int ACC_W = 35 + $clog2(DIM);
  localparam logic signed [ACC_W-1:0] HMAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] HMIN = -ACC_W'(32768);

  lrs_pkg::state_t state, state_next;

  logic [HAW-1:0]  clr_cnt;
  logic [CW-1:0]   c_cnt;
  logic [CW-1:0]   r_cnt;
  logic [lrs_pkg::LANE_W-1:0] cur_lane;
  logic [HAW-1:0]  lane_base;
  logic            pop;
  logic            issue_sum;
  logic            issue_mac;
  logic            load_fire;
  logic            c_last;
  logic            r_last;

  logic            rv;
  logic [DAW-1:0]  rv_idx;
  logic            p1, f1, l1;
  logic            p2, f2, l2;
  logic signed [15:0]      bias_q;
  logic signed [32:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] t_rnd;
  logic signed [ACC_W-1:0] t_sh;
  logic signed [15:0]      hq;
  logic [16:0]             sig;
  logic signed [33:0]      gprod;
  logic signed [33:0]      g_rnd;

  logic            w_we, b_we, h_we, s_we;
  logic [WAW-1:0]  w_waddr, w_raddr;
  logic [DAW-1:0]  b_waddr, b_raddr, u_raddr;
  logic [HAW-1:0]  h_waddr, s_waddr, hs_raddr;
  logic [15:0]     b_wdata, h_wdata;
  logic [15:0]     w_rd, b_rd, h_rd, s_rd;
  logic [16:0]     u_wdata, u_rd;

  assign c_last    = c_cnt == CW'(32'(n) - 1);
  assign r_last    = r_cnt == CW'(32'(n) - 1);
  assign lane_base = HAW'(32'(cur_lane) * DIM);
  assign cmd_ready = state == lrs_pkg::S_IDLE;
  assign pop       = cmd_valid && cmd_ready;
  assign stat.clearing = state == lrs_pkg::S_CLEAR;
  assign stat.busy     = state != lrs_pkg::S_IDLE;

  always_comb begin
    state_next = state;
    issue_sum  = 1'b0;
    issue_mac  = 1'b0;
    load_fire  = 1'b0;
    unique case (state)
      lrs_pkg::S_CLEAR:
        if (clr_cnt == HAW'(LANES * DIM - 1)) state_next = lrs_pkg::S_IDLE;
      lrs_pkg::S_IDLE:
        if (pop && cmd.kind == lrs_pkg::K_STEP) state_next = lrs_pkg::S_SUM;
      lrs_pkg::S_SUM: begin
        issue_sum = 1'b1;
        if (c_last) state_next = lrs_pkg::S_SUMW;
      end
      lrs_pkg::S_SUMW: state_next = lrs_pkg::S_MAC;
      lrs_pkg::S_MAC: begin
        issue_mac = 1'b1;
        if (c_last) state_next = lrs_pkg::S_WAIT;
      end
      lrs_pkg::S_WAIT:
        if (p2 && l2) state_next = lrs_pkg::S_SAT;
      lrs_pkg::S_SAT: state_next = lrs_pkg::S_SIG;
      lrs_pkg::S_SIG: state_next = lrs_pkg::S_MUL;
      lrs_pkg::S_MUL: state_next = lrs_pkg::S_LOAD;
      lrs_pkg::S_LOAD:
        if (!out_valid || out_ready) begin
          load_fire  = 1'b1;
          state_next = r_last ? lrs_pkg::S_IDLE : lrs_pkg::S_MAC;
        end
      default: state_next = lrs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lrs_pkg::S_CLEAR;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      c_cnt     <= '0;
      r_cnt     <= '0;
      rv        <= 1'b0;
      p1        <= 1'b0;
      p2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == lrs_pkg::S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (issue_sum || issue_mac) c_cnt <= c_last ? '0 : c_cnt + 1'b1;
      if (load_fire) r_cnt <= r_last ? '0 : r_cnt + 1'b1;
      rv <= issue_sum;
      p1 <= issue_mac;
      p2 <= p1;
      if (load_fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    t_rnd = acc + ACC_W'(128);
    t_sh  = t_rnd >>> 8;
    g_rnd = gprod + 34'sd32768;
  end

  always_ff @(posedge clk) begin
    if (pop) cur_lane <= cmd.lane;
    rv_idx <= DAW'(c_cnt);
    f1 <= c_cnt == '0;
    l1 <= c_last;
    if (p1) prod <= $signed(w_rd) * $signed(u_rd);
    if (p1 && f1) bias_q <= $signed(b_rd);
    f2 <= f1;
    l2 <= l1;
    if (p2) acc <= (f2 ? (ACC_W'(bias_q) <<< 8) : acc) + ACC_W'(prod);
    if (state == lrs_pkg::S_SAT) begin
      if (t_sh > HMAX) hq <= 16'sh7fff;
      else if (t_sh < HMIN) hq <= -16'sh8000;
      else hq <= t_sh[15:0];
    end
    if (state == lrs_pkg::S_SIG) begin
      if (hq < -16'sd2048) sig <= 17'd0;
      else if (hq >= 16'sd2048) sig <= 17'h10000;
      else sig <= {1'b0, lrs_pkg::SIG_ROM[{~hq[11], hq[10:4]}]};
    end
    if (state == lrs_pkg::S_MUL) gprod <= hq * $signed({1'b0, sig});
    if (load_fire) begin
      out_lane     <= cur_lane;
      out_row      <= lrs_pkg::IDX_W'(r_cnt);
      hidden_value <= hq;
      gated_value  <= g_rnd[31:16];
      last_row     <= r_last;
    end
  end

  // store writes: clearing pass, loads from the queue, new hidden rows
  always_comb begin
    w_we    = pop && cmd.kind == lrs_pkg::K_WEIGHT;
    w_waddr = WAW'(32'(cmd.row) * DIM + 32'(cmd.col));
    w_raddr = WAW'(32'(r_cnt) * DIM + 32'(c_cnt));

    b_we    = (state == lrs_pkg::S_CLEAR && 32'(clr_cnt) < DIM)
           || (pop && cmd.kind == lrs_pkg::K_BIAS);
    b_waddr = (state == lrs_pkg::S_CLEAR) ? DAW'(clr_cnt) : DAW'(cmd.row);
    b_wdata = (state == lrs_pkg::S_CLEAR) ? 16'd0 : cmd.value;
    b_raddr = DAW'(r_cnt);

    h_we    = state == lrs_pkg::S_CLEAR || load_fire
           || (pop && cmd.kind == lrs_pkg::K_HIDDEN);
    if (state == lrs_pkg::S_CLEAR) begin
      h_waddr = clr_cnt;
      h_wdata = 16'd0;
    end else if (load_fire) begin
      h_waddr = lane_base + HAW'(r_cnt);
      h_wdata = hq;
    end else begin
      h_waddr = HAW'(32'(cmd.lane) * DIM + 32'(cmd.row));
      h_wdata = cmd.value;
    end

    s_we    = pop && (cmd.kind == lrs_pkg::K_SAMPLE || cmd.kind == lrs_pkg::K_STEP);
    s_waddr = HAW'(32'(cmd.lane) * DIM + 32'(cmd.col));
    hs_raddr = lane_base + HAW'(c_cnt);

    u_wdata = {s_rd[15], s_rd} + {h_rd[15], h_rd};
    u_raddr = DAW'(c_cnt);
  end

  lrs_ram #(.WIDTH(16), .DEPTH(DIM * DIM)) u_weight (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(cmd.value),
    .raddr(w_raddr), .rdata(w_rd)
  );

  lrs_ram #(.WIDTH(16), .DEPTH(DIM)) u_bias (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rd)
  );

  lrs_ram #(.WIDTH(16), .DEPTH(LANES * DIM)) u_hidden (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(hs_raddr), .rdata(h_rd)
  );

  lrs_ram #(.WIDTH(16), .DEPTH(LANES * DIM)) u_sample (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(cmd.value),
    .raddr(hs_raddr), .rdata(s_rd)
  );

  // x + h per column, so each row needs one product per column
  lrs_ram #(.WIDTH(17), .DEPTH(DIM)) u_sum (
    .clk(clk), .we(rv), .waddr(rv_idx), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rd)
  );

endmodule

// ===== src/linear_rnn_silu_cell_top.sv =====
// Channel    Handshake            Payload
// in         in_valid/in_ready    opcode, lane, row_index, col_index, value
// out        out_valid/out_ready  out_lane, out_row, hidden_value, gated_value, last_row
// cfg        cfg_we               cfg_wdata (active_dim)
//
// A load or a non-closing sample item is executed as the idle back end accepts it.
// The closing sample of a vector of length n first sums x + h per column, then
// one shared 16x17 multiply-accumulate does one product per cycle in a row, row by row.
// After reset a clearing pass over LANES*DIM entries zeroes bias and hidden stores;
// in_ready stays low during it. A two-item queue separates front and back, and the
// output register lets the back end start the next row while a result waits.
`include "linear_rnn_silu_cell_top_assert.svh"
module linear_rnn_silu_cell_top #(
  parameter int DIM   = lrs_pkg::DIM_DEF,
  parameter int LANES = lrs_pkg::LANES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         opcode,
  input  logic [lrs_pkg::LANE_W-1:0]         lane,
  input  logic [lrs_pkg::IDX_W-1:0]          row_index,
  input  logic [lrs_pkg::IDX_W-1:0]          col_index,
  input  logic signed [lrs_pkg::VAL_W-1:0]   value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lrs_pkg::LANE_W-1:0]         out_lane,
  output logic [lrs_pkg::IDX_W-1:0]          out_row,
  output logic signed [lrs_pkg::VAL_W-1:0]   hidden_value,
  output logic signed [lrs_pkg::VAL_W-1:0]   gated_value,
  output logic                               last_row,
  input  logic                               cfg_we,
  input  logic [lrs_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int CW = lrs_pkg::aw(DIM + 1);

  logic [lrs_pkg::CFG_W-1:0] active_dim;
  logic [CW-1:0]             n;
  logic                      cmd_valid;
  logic                      cmd_ready;
  lrs_pkg::cmd_t             cmd;
  lrs_pkg::back_stat_t       stat;

  always_ff @(posedge clk) begin
    if (rst) active_dim <= lrs_pkg::CFG_W'(lrs_pkg::ACTIVE_DIM_RESET);
    else if (cfg_we) active_dim <= cfg_wdata;
  end

  // clamp the length to [1, DIM]
  always_comb begin
    if (active_dim == '0) n = CW'(1);
    else if (32'(active_dim) > DIM) n = CW'(DIM);
    else n = CW'(active_dim);
  end

  lrs_front #(.DIM(DIM), .LANES(LANES)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .lane(lane), .row_index(row_index),
    .col_index(col_index), .value(value),
    .n(n), .hold(stat.clearing),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  lrs_back #(.DIM(DIM), .LANES(LANES)) u_back (
    .clk(clk), .rst(rst), .n(n),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .stat(stat),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_lane(out_lane), .out_row(out_row),
    .hidden_value(hidden_value), .gated_value(gated_value),
    .last_row(last_row)
  );

  `LRS_ASSERT_IMPLY(a_no_accept_in_clear, stat.clearing, !in_ready)
  `LRS_ASSERT_IMPLY(a_last_row_pos, out_valid && last_row, 32'(out_row) == 32'(n) - 1)
  `LRS_ASSERT_IMPLY(a_row_in_range, out_valid && !last_row, 32'(out_row) < 32'(n) - 1)
  `LRS_ASSERT_IMPLY(a_lane_in_range, out_valid, 32'(out_lane) < LANES)

endmodule
